>>> rtl/lmpba_pkg.sv
// Shared types and constants of the low-memory page bitmap allocator.
package lmpba_pkg;

	localparam int MEM_LIMIT    = 1024 * 1024;
	localparam int ADDR_LIMIT_W = 20;
	localparam int WORD_W       = 32;
	localparam int BIT_W        = 5;
	// Widest page index over the supported page sizes (1 MB / 512 B).
	localparam int IDX_MAX_W    = 11;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_MARK,
		CMD_ALLOC,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [IDX_MAX_W-1:0]   first;
		logic [IDX_MAX_W-1:0]   last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_RESULT
	} back_state_t;

endpackage

>>> rtl/lmpba_if.sv
// Request and response channel interfaces of the page allocator.
interface lmpba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] address;
	logic [31:0] length;

	modport source(output valid, opcode, address, length, input ready);
	modport sink(input valid, opcode, address, length, output ready);
endinterface

interface lmpba_rsp_if;
	logic        valid;
	logic        ready;
	logic [19:0] page_address;
	logic        out_of_pages;

	modport source(output valid, page_address, out_of_pages, input ready);
	modport sink(input valid, page_address, out_of_pages, output ready);
endinterface

>>> rtl/lmpba_ram.sv
// Generic simple dual-port RAM with registered read.
module lmpba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/lmpba_front.sv
// Front end: accepts requests and turns them into clipped page-range commands.
module lmpba_front import lmpba_pkg::*; #(
	parameter int PAGE_BYTES = 4096,
	parameter int PAGE_COUNT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	lmpba_req_if.sink     req,
	input  logic          queue_full,
	output logic          push,
	output cmd_t          push_cmd
);
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int LIMIT_PAGES = MEM_LIMIT / PAGE_BYTES;
	localparam int LIVE_PAGES  = (PAGE_COUNT < LIMIT_PAGES) ? PAGE_COUNT : LIMIT_PAGES;
	localparam int PG_W        = ADDR_LIMIT_W - PAGE_SHIFT;

	logic                    below_limit;
	logic [32:0]             end_m1;
	logic [ADDR_LIMIT_W-1:0] last_byte;
	logic [PG_W-1:0]         first_pg;
	logic [PG_W-1:0]         last_pg;
	logic [PG_W-1:0]         last_clip;
	logic                    first_live;
	cmd_t                    cmd_d;
	logic                    vld_s1;
	cmd_t                    cmd_s1;

	always_comb begin
		below_limit = (req.address[31:ADDR_LIMIT_W] == '0);
		end_m1      = {1'b0, req.address} + {1'b0, req.length} - 33'd1;
		last_byte   = (end_m1[32:ADDR_LIMIT_W] != '0) ? '1 : end_m1[ADDR_LIMIT_W-1:0];
		first_pg    = req.address[ADDR_LIMIT_W-1:PAGE_SHIFT];
		last_pg     = last_byte[ADDR_LIMIT_W-1:PAGE_SHIFT];
		first_live  = {1'b0, first_pg} < (PG_W+1)'(LIVE_PAGES);
		last_clip   = ({1'b0, last_pg} < (PG_W+1)'(LIVE_PAGES)) ? last_pg
			: PG_W'(LIVE_PAGES - 1);
		cmd_d.kind  = CMD_NONE;
		cmd_d.first = IDX_MAX_W'(first_pg);
		cmd_d.last  = IDX_MAX_W'(last_clip);
		case (op_t'(req.opcode))
			OP_RESERVE: begin
				if (below_limit && (req.length != '0) && first_live) begin
					cmd_d.kind = CMD_MARK;
				end
			end
			OP_ALLOC: begin
				cmd_d.kind = CMD_ALLOC;
			end
			OP_RELEASE: begin
				if ((req.address != '0) && below_limit && first_live) begin
					cmd_d.kind = CMD_CLEAR;
				end
			end
			default: begin
				cmd_d.kind = CMD_NONE;
			end
		endcase
	end

	assign push      = vld_s1 && !queue_full;
	assign push_cmd  = cmd_s1;
	assign req.ready = !vld_s1 || !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= cmd_d;
		end
	end
endmodule

>>> rtl/lmpba_fifo.sv
// Two-entry command queue between front end and back end.
module lmpba_fifo import lmpba_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head,
	output queue_status_t status
);
	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

>>> rtl/lmpba_back.sv
// Back end: word-serial read-modify-write of the page bitmap and result register.
module lmpba_back import lmpba_pkg::*; #(
	parameter int PAGE_BYTES = 4096,
	parameter int PAGE_COUNT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          head,
	input  queue_status_t status,
	output logic          pop,
	lmpba_rsp_if.source   rsp
);
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int LIMIT_PAGES = MEM_LIMIT / PAGE_BYTES;
	localparam int LIVE_PAGES  = (PAGE_COUNT < LIMIT_PAGES) ? PAGE_COUNT : LIMIT_PAGES;
	localparam int NWORDS      = (LIVE_PAGES + WORD_W - 1) / WORD_W;
	localparam int WIDX_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int TAIL        = LIVE_PAGES % WORD_W;
	localparam logic [WORD_W-1:0] TAIL_MASK = (TAIL == 0) ? '0 : ({WORD_W{1'b1}} << TAIL);
	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

	back_state_t             state_q, state_d;
	cmd_t                    cmd_q, cmd_d;
	logic [WIDX_W-1:0]       w_q, w_d;
	logic [ADDR_LIMIT_W-1:0] res_addr_q, res_addr_d;
	logic                    res_oop_q, res_oop_d;
	logic                    load_out;
	logic                    out_vld_q;
	logic [ADDR_LIMIT_W-1:0] out_addr_q;
	logic                    out_oop_q;
	logic [NWORDS-1:0]       vld_q;

	logic                    ram_we;
	logic [WORD_W-1:0]       ram_wdata;
	logic [WORD_W-1:0]       ram_rdata;
	logic [WORD_W-1:0]       eff;
	logic [WIDX_W-1:0]       fw, lw;
	logic [BIT_W-1:0]        lo, hi, lo_eff, hi_eff;
	logic [WORD_W-1:0]       mark_mask;
	logic [WORD_W-1:0]       excl;
	logic [WORD_W-1:0]       cand;
	logic                    found;
	logic [BIT_W-1:0]        bsel;
	logic [31:0]             page_byte;

	lmpba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NWORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (w_q),
		.wdata (ram_wdata),
		.raddr (w_q),
		.rdata (ram_rdata)
	);

	// word datapath
	always_comb begin
		eff       = vld_q[w_q] ? ram_rdata : '0;
		fw        = WIDX_W'(cmd_q.first >> BIT_W);
		lw        = WIDX_W'(cmd_q.last >> BIT_W);
		lo        = cmd_q.first[BIT_W-1:0];
		hi        = cmd_q.last[BIT_W-1:0];
		lo_eff    = (w_q == fw) ? lo : '0;
		hi_eff    = (w_q == lw) ? hi : '1;
		mark_mask = ({WORD_W{1'b1}} << lo_eff) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_eff));
		excl      = (w_q == LAST_WORD) ? TAIL_MASK : '0;
		if (w_q == '0) begin
			excl[0] = 1'b1;
		end
		cand  = ~eff & ~excl;
		found = |cand;
		bsel  = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				bsel = BIT_W'(b);
			end
		end
		page_byte = 32'({w_q, bsel}) << PAGE_SHIFT;
	end

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		w_d        = w_q;
		res_addr_d = res_addr_q;
		res_oop_d  = res_oop_q;
		pop        = 1'b0;
		ram_we     = 1'b0;
		ram_wdata  = eff;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!status.empty) begin
					pop        = 1'b1;
					cmd_d      = head;
					res_addr_d = '0;
					res_oop_d  = 1'b0;
					w_d        = (head.kind == CMD_ALLOC) ? '0 : WIDX_W'(head.first >> BIT_W);
					state_d    = (head.kind == CMD_NONE) ? ST_RESULT : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				case (cmd_q.kind)
					CMD_MARK: begin
						ram_we    = 1'b1;
						ram_wdata = eff | mark_mask;
						if (w_q == lw) begin
							state_d = ST_RESULT;
						end else begin
							w_d     = w_q + 1'b1;
							state_d = ST_READ;
						end
					end
					CMD_CLEAR: begin
						ram_we    = 1'b1;
						ram_wdata = eff & ~(WORD_W'(1) << lo);
						state_d   = ST_RESULT;
					end
					CMD_ALLOC: begin
						if (found) begin
							ram_we     = 1'b1;
							ram_wdata  = eff | (WORD_W'(1) << bsel);
							res_addr_d = page_byte[ADDR_LIMIT_W-1:0];
							state_d    = ST_RESULT;
						end else if (w_q == LAST_WORD) begin
							res_oop_d = 1'b1;
							state_d   = ST_RESULT;
						end else begin
							w_d     = w_q + 1'b1;
							state_d = ST_READ;
						end
					end
					default: begin
						state_d = ST_RESULT;
					end
				endcase
			end
			ST_RESULT: begin
				if (!out_vld_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			vld_q     <= '0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ram_we) begin
				vld_q[w_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		w_q        <= w_d;
		res_addr_q <= res_addr_d;
		res_oop_q  <= res_oop_d;
		if (load_out) begin
			out_addr_q <= res_addr_q;
			out_oop_q  <= res_oop_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.page_address = out_addr_q;
	assign rsp.out_of_pages = out_oop_q;

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_RESULT))
		else $error("result register loaded outside result state");

	a_oop_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_oop_q |-> out_addr_q == '0)
		else $error("failed allocate carries a nonzero address");

	a_we_modify: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_MODIFY)
		else $error("bitmap write outside modify state");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE && !status.empty)
		else $error("queue popped while busy or empty");
endmodule

>>> rtl/low_memory_page_bitmap_allocator.sv
// Top level of the low-memory page bitmap allocator.
//
//   channel  dir  payload                          transfer when
//   req      in   opcode, address, length          req.valid && req.ready
//   rsp      out  page_address, out_of_pages       rsp.valid && rsp.ready
//
// The bitmap sits in a RAM of 32-bit words, one read-modify-write per word
// through a read state and a modify state. Release touches one word, reserve
// every word it spans, and allocate scans up from word 0 to the first free
// page, behind a front stage and the queue. Reset clears per-word valid bits,
// so the map reads as all free at once. Each side stalls on its own behind the
// two-entry queue and the result register.
module low_memory_page_bitmap_allocator import lmpba_pkg::*; #(
	parameter int PAGE_BYTES = 4096,
	parameter int PAGE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	lmpba_req_if.sink   req,
	lmpba_rsp_if.source rsp
);
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          head;
	queue_status_t status;

	lmpba_front #(
		.PAGE_BYTES(PAGE_BYTES),
		.PAGE_COUNT(PAGE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.queue_full (status.full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	lmpba_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	lmpba_back #(
		.PAGE_BYTES(PAGE_BYTES),
		.PAGE_COUNT(PAGE_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (status),
		.pop    (pop),
		.rsp    (rsp)
	);
endmodule
